// File: rtl/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Command and status codes, microcode word layout and the control store of
// the linked list sequencer.
// ----------------------------------------------------------------------------
package dll_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_REMOVE     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_t;

  // Microprogram steps
  typedef enum logic [2:0] {
    U_FETCH  = 3'd0,
    U_ALLOC  = 3'd1,
    U_INIT   = 3'd2,
    U_LINK   = 3'd3,
    U_POP_RD = 3'd4,
    U_UNLINK = 3'd5,
    U_RM_RD  = 3'd6,
    U_FAULT  = 3'd7
  } upc_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ALLOC,
    ACT_INIT,
    ACT_LINK,
    ACT_READ,
    ACT_UNLINK,
    ACT_REPORT
  } act_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_FULL,
    COND_EMPTY,
    COND_RANGE,
    COND_BAD
  } cond_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_GOTO,
    SEQ_FETCH,
    SEQ_DISPATCH
  } seq_t;

  typedef struct packed {
    act_t    act;
    cond_t   cond;     // when true: skip the action, jump to U_FAULT
    seq_t    seq;
    upc_t    target;
    logic    respond;  // step delivers the result item
    status_t fail;     // status reported when cond is taken
  } uword_t;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{act: ACT_NONE, cond: COND_NONE, seq: SEQ_NEXT, target: U_FETCH,
          respond: 1'b0, fail: ST_OK};
    unique case (a)
      U_FETCH: begin
        w.seq = SEQ_DISPATCH;
      end
      U_ALLOC: begin
        w.act  = ACT_ALLOC;
        w.cond = COND_FULL;
        w.fail = ST_FULL;
      end
      U_INIT: begin
        w.act = ACT_INIT;
      end
      U_LINK: begin
        w.act     = ACT_LINK;
        w.respond = 1'b1;
        w.seq     = SEQ_FETCH;
      end
      U_POP_RD: begin
        w.act  = ACT_READ;
        w.cond = COND_EMPTY;
        w.fail = ST_EMPTY;
      end
      U_UNLINK: begin
        w.act     = ACT_UNLINK;
        w.cond    = COND_BAD;
        w.fail    = ST_BAD_SLOT;
        w.respond = 1'b1;
        w.seq     = SEQ_FETCH;
      end
      U_RM_RD: begin
        w.act    = ACT_READ;
        w.cond   = COND_RANGE;
        w.fail   = ST_BAD_SLOT;
        w.seq    = SEQ_GOTO;
        w.target = U_UNLINK;
      end
      U_FAULT: begin
        w.act     = ACT_REPORT;
        w.respond = 1'b1;
        w.seq     = SEQ_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/dll_ram.sv
// ----------------------------------------------------------------------------
// dll_ram
// Simple dual-port RAM: one write port, one read port with registered data
// that holds while the read enable is low.
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/doubly_linked_list_engine.sv
// Steps per item: push runs alloc, init and link; pop runs read and unlink;
// remove runs read with a range check, then unlink; a failed check or an
// unused command ends in the fault step. The steps are set around the single
// write port of each link memory; a new item is taken only back in fetch.
// Reset (rst, synchronous): list empty, all slots free, no result pending;
// no clearing pass, the block can take an item as soon as reset is released.
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Doubly linked list over a fixed pool of slots with a free stack, run by a
// microcoded sequencer over a plain datapath of node and free-stack RAMs.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine
  import dll_pkg::*;
#(
  parameter int POOL_DEPTH    = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] payload,
  input  logic [5:0]  slot_handle,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] out_payload,
  output logic [5:0]  out_handle,
  output logic [1:0]  status,
  output logic [6:0]  element_total
);

  localparam int IW  = $clog2(POOL_DEPTH);
  localparam int LW  = $clog2(POOL_DEPTH + 1);
  localparam int HCW = LW + 6;
  localparam logic [LW-1:0] NONE = LW'(POOL_DEPTH);

  // sequencer
  upc_t   upc, upc_next;
  uword_t uw;
  logic   item_accept, out_free, cond_hit, hold, go;

  // control registers
  logic [LW-1:0] head, tail, count, free_top, low_mark;
  status_t       fail_r;

  // payload registers
  cmd_t                    cmd_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic [5:0]              hdl_r;
  logic [IW-1:0]           slot_r, alloc_val_r;
  logic                    alloc_virgin_r, node_virgin_r;
  status_t                 status_r;

  // memory ports
  logic                     val_we, next_we, prev_we, use_we, free_we, free_re, node_re;
  logic [IW-1:0]            val_waddr, next_waddr, prev_waddr, use_waddr, free_waddr;
  logic [IW-1:0]            node_addr, free_raddr;
  logic [PAYLOAD_WIDTH-1:0] val_wdata, val_rdata;
  logic [LW-1:0]            next_wdata, prev_wdata, next_rdata, prev_rdata;
  logic                     use_wdata, use_rdata;
  logic [IW-1:0]            free_wdata, free_rdata;

  logic [LW-1:0] ft_dec, after, prior;
  logic [IW-1:0] s_new;
  logic          has_head;

  assign uw          = ucode(upc);
  assign item_stall  = (upc != U_FETCH);
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;

  assign ft_dec   = free_top - 1'b1;
  assign s_new    = alloc_virgin_r ? alloc_val_r : free_rdata;
  assign after    = next_rdata;
  assign prior    = prev_rdata;
  assign has_head = (head != NONE);
  assign node_addr = (cmd_r == CMD_REMOVE)   ? IW'(hdl_r) :
                     (cmd_r == CMD_POP_BACK) ? IW'(tail)  : IW'(head);

  always_comb begin
    case (uw.cond)
      COND_FULL:  cond_hit = (free_top == '0);
      COND_EMPTY: cond_hit = !has_head;
      COND_RANGE: cond_hit = (HCW'(hdl_r) >= HCW'(POOL_DEPTH));
      COND_BAD:   cond_hit = (cmd_r == CMD_REMOVE) && (node_virgin_r || !use_rdata);
      default:    cond_hit = 1'b0;
    endcase
  end

  assign hold = uw.respond && !cond_hit && !out_free;
  assign go   = !cond_hit && !hold;

  // next step
  always_comb begin
    upc_next = upc;
    if (cond_hit) begin
      upc_next = U_FAULT;
    end else if (!hold) begin
      unique case (uw.seq)
        SEQ_NEXT:  upc_next = upc_t'(upc + 3'd1);
        SEQ_GOTO:  upc_next = uw.target;
        SEQ_FETCH: upc_next = U_FETCH;
        SEQ_DISPATCH: begin
          if (item_accept) begin
            unique case (cmd) inside
              CMD_PUSH_BACK, CMD_PUSH_FRONT: upc_next = U_ALLOC;
              CMD_POP_BACK, CMD_POP_FRONT:   upc_next = U_POP_RD;
              CMD_REMOVE:                    upc_next = U_RM_RD;
              default:                       upc_next = U_FAULT;
            endcase
          end
        end
      endcase
    end
  end

  // datapath controls
  always_comb begin
    val_we     = 1'b0;
    val_waddr  = '0;
    val_wdata  = '0;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    use_we     = 1'b0;
    use_waddr  = '0;
    use_wdata  = 1'b0;
    free_we    = 1'b0;
    free_waddr = '0;
    free_wdata = '0;
    free_re    = 1'b0;
    free_raddr = '0;
    node_re    = 1'b0;
    if (go) begin
      unique case (uw.act)
        ACT_ALLOC: begin
          free_re    = 1'b1;
          free_raddr = IW'(ft_dec);
        end
        ACT_INIT: begin
          val_we     = 1'b1;
          val_waddr  = s_new;
          val_wdata  = pay_r;
          use_we     = 1'b1;
          use_waddr  = s_new;
          use_wdata  = 1'b1;
          next_we    = 1'b1;
          next_waddr = s_new;
          next_wdata = (has_head && cmd_r == CMD_PUSH_FRONT) ? head : NONE;
          prev_we    = 1'b1;
          prev_waddr = s_new;
          prev_wdata = (has_head && cmd_r == CMD_PUSH_BACK) ? tail : NONE;
        end
        ACT_LINK: begin
          if (has_head) begin
            if (cmd_r == CMD_PUSH_BACK) begin
              next_we    = 1'b1;
              next_waddr = IW'(tail);
              next_wdata = LW'(slot_r);
            end else begin
              prev_we    = 1'b1;
              prev_waddr = IW'(head);
              prev_wdata = LW'(slot_r);
            end
          end
        end
        ACT_READ: begin
          node_re = 1'b1;
        end
        ACT_UNLINK: begin
          if (prior != NONE) begin
            next_we    = 1'b1;
            next_waddr = IW'(prior);
            next_wdata = after;
          end
          if (after != NONE) begin
            prev_we    = 1'b1;
            prev_waddr = IW'(after);
            prev_wdata = prior;
          end
          use_we    = 1'b1;
          use_waddr = slot_r;
          use_wdata = 1'b0;
          if (free_top < NONE) begin
            free_we    = 1'b1;
            free_waddr = IW'(free_top);
            free_wdata = slot_r;
          end
        end
        ACT_NONE, ACT_REPORT: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= U_FETCH;
      head         <= NONE;
      tail         <= NONE;
      count        <= '0;
      free_top     <= NONE;
      low_mark     <= NONE;
      fail_r       <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (item_accept) begin
        fail_r <= ST_OK;
      end
      if (cond_hit) begin
        fail_r <= uw.fail;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (go && uw.respond) begin
        result_valid <= 1'b1;
      end
      if (go) begin
        case (uw.act)
          ACT_ALLOC: begin
            free_top <= ft_dec;
            // low_mark: lowest free_top so far; entries below it are untouched
            if (ft_dec < low_mark) begin
              low_mark <= ft_dec;
            end
          end
          ACT_LINK: begin
            if (!has_head) begin
              head <= LW'(slot_r);
              tail <= LW'(slot_r);
            end else if (cmd_r == CMD_PUSH_BACK) begin
              tail <= LW'(slot_r);
            end else begin
              head <= LW'(slot_r);
            end
            count <= count + 1'b1;
          end
          ACT_UNLINK: begin
            if (prior == NONE) begin
              head <= after;
            end
            if (after == NONE) begin
              tail <= prior;
            end
            if (free_top < NONE) begin
              free_top <= free_top + 1'b1;
            end
            if (count != '0) begin
              count <= count - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_accept) begin
      cmd_r <= cmd_t'(cmd);
      pay_r <= PAYLOAD_WIDTH'(payload);
      hdl_r <= slot_handle;
    end
    if (go) begin
      case (uw.act)
        ACT_ALLOC: begin
          // untouched free-stack entry i holds POOL_DEPTH-1-i
          alloc_virgin_r <= (ft_dec < low_mark);
          alloc_val_r    <= IW'(NONE - free_top);
        end
        ACT_INIT: begin
          slot_r <= s_new;
        end
        ACT_LINK: begin
          out_payload <= '0;
          out_handle  <= 6'(slot_r);
          status_r    <= ST_OK;
        end
        ACT_READ: begin
          slot_r <= node_addr;
          // slots never handed out have no valid in-use entry
          node_virgin_r <= (LW'(node_addr) >= (NONE - low_mark));
        end
        ACT_UNLINK: begin
          out_payload <= 32'(val_rdata);
          out_handle  <= 6'(slot_r);
          status_r    <= ST_OK;
        end
        ACT_REPORT: begin
          out_payload <= '0;
          out_handle  <= '0;
          status_r    <= fail_r;
        end
        default: begin
        end
      endcase
    end
    if (go && uw.respond) begin
      element_total <= (uw.act == ACT_LINK)   ? 7'(count + 1'b1) :
                       (uw.act == ACT_UNLINK) ? 7'((count != '0) ? count - 1'b1 : count) :
                                                7'(count);
    end
  end

  assign status = status_r;

  dll_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(POOL_DEPTH)) u_value (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .re(node_re), .raddr(node_addr), .rdata(val_rdata)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .re(node_re), .raddr(node_addr), .rdata(next_rdata)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .re(node_re), .raddr(node_addr), .rdata(prev_rdata)
  );

  dll_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_in_use (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .re(node_re), .raddr(node_addr), .rdata(use_rdata)
  );

  dll_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_free (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .re(free_re), .raddr(free_raddr), .rdata(free_rdata)
  );

`ifndef SYNTHESIS
  // every slot is either on the list or on the free stack between items
  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    (upc == U_FETCH) |-> ((LW+1)'(count) + (LW+1)'(free_top) == (LW+1)'(POOL_DEPTH)))
    else $error("slot count and free stack out of balance");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (upc == U_FETCH) |-> ((count == '0) == (head == NONE) && (head == NONE) == (tail == NONE)))
    else $error("head/tail disagree with element count");

  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= free_top)
    else $error("free stack low mark above free top");

  a_result_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(result_valid) && result_valid) |-> $past(uw.respond))
    else $error("result raised outside a responding step");
`endif

endmodule

// File: test/tb_doubly_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_engine
// Self-checking bench for the linked list engine. A directed table covers the
// empty, bad-slot and unused-command cases. Random phases then fill the pool,
// drain it and remove live slots. Each result is checked against the directed
// table outcome or a behavioral list kept in the bench, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_engine;
  import dll_pkg::*;

  localparam int         SLOTS        = 64;
  localparam logic [6:0] NIL          = 7'd64;
  localparam int         RANDOM_ITEMS = 1500;
  localparam int         MAX_WAIT     = 17;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         MAX_REPORTS  = 10;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  slot;
    status_t     code;
    logic [6:0]  total;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [5:0]  slot;
    logic        typed;
    outcome_t    want;
  } row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_POP_BACK,   32'h0,         6'd0,  1'b1, '{32'h0, 6'd0, ST_EMPTY, 7'd0}},
    '{CMD_POP_FRONT,  32'h0,         6'd0,  1'b1, '{32'h0, 6'd0, ST_EMPTY, 7'd0}},
    '{CMD_REMOVE,     32'h0,         6'd0,  1'b1, '{32'h0, 6'd0, ST_BAD_SLOT, 7'd0}},
    '{CMD_REMOVE,     32'h0,         6'd63, 1'b1, '{32'h0, 6'd0, ST_BAD_SLOT, 7'd0}},
    '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 6'd63, 1'b1, '{32'h0, 6'd0, ST_OK, 7'd1}},
    '{CMD_PUSH_FRONT, 32'h0,         6'd0,  1'b1, '{32'h0, 6'd1, ST_OK, 7'd2}},
    '{CMD_PUSH_BACK,  32'hA5A5_5A5A, 6'd0,  1'b1, '{32'h0, 6'd2, ST_OK, 7'd3}},
    '{CMD_SPARE_LO,   32'hFFFF_FFFF, 6'd63, 1'b1, '{32'h0, 6'd0, ST_OK, 7'd3}},
    '{CMD_SPARE_MID,  32'h1234_5678, 6'd1,  1'b1, '{32'h0, 6'd0, ST_OK, 7'd3}},
    '{CMD_SPARE_HI,   32'h0,         6'd2,  1'b1, '{32'h0, 6'd0, ST_OK, 7'd3}},
    // middle node out, then the same slot again is stale
    '{CMD_REMOVE,     32'h0,         6'd0,  1'b0, '0},
    '{CMD_REMOVE,     32'h0,         6'd0,  1'b1, '{32'h0, 6'd0, ST_BAD_SLOT, 7'd2}},
    '{CMD_POP_BACK,   32'h0,         6'd0,  1'b0, '0},
    '{CMD_PUSH_FRONT, 32'h8000_0001, 6'd0,  1'b0, '0},
    '{CMD_POP_FRONT,  32'h0,         6'd0,  1'b0, '0},
    '{CMD_POP_FRONT,  32'h0,         6'd0,  1'b0, '0},
    '{CMD_POP_BACK,   32'h0,         6'd0,  1'b1, '{32'h0, 6'd0, ST_EMPTY, 7'd0}},
    '{CMD_REMOVE,     32'h0,         6'd63, 1'b1, '{32'h0, 6'd0, ST_BAD_SLOT, 7'd0}},
    '{CMD_PUSH_BACK,  32'h0000_0001, 6'd0,  1'b0, '0},
    '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 6'd0,  1'b0, '0},
    // tail by handle, then the last node by handle
    '{CMD_REMOVE,     32'h0,         6'd2,  1'b0, '0},
    '{CMD_REMOVE,     32'h0,         6'd1,  1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [2:0]  cmd;
  logic [31:0] payload;
  logic [5:0]  slot_handle;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] out_payload;
  logic [5:0]  out_handle;
  logic [1:0]  status;
  logic [6:0]  element_total;

  // bench copy of the list
  logic [31:0] node_val  [SLOTS];
  logic [6:0]  node_next [SLOTS];
  logic [6:0]  node_prev [SLOTS];
  bit          in_use    [SLOTS];
  logic [5:0]  free_slots [SLOTS];
  int          free_cnt;
  logic [6:0]  first_slot;
  logic [6:0]  last_slot;
  int          live_count;

  outcome_t pending_outcomes [$];
  int       mismatches;
  bit       tx_burst;
  bit       rx_burst;

  doubly_linked_list_engine i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .payload       (payload),
    .slot_handle   (slot_handle),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_payload   (out_payload),
    .out_handle    (out_handle),
    .status        (status),
    .element_total (element_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_list();
    for (int i = 0; i < SLOTS; i++) begin
      in_use[i]     = 1'b0;
      free_slots[i] = 6'(SLOTS - 1 - i);
    end
    free_cnt   = SLOTS;
    first_slot = NIL;
    last_slot  = NIL;
    live_count = 0;
  endfunction

  function automatic void detach_slot(input logic [5:0] s);
    logic [6:0] after;
    logic [6:0] ahead;
    after = node_next[s];
    ahead = node_prev[s];
    if (ahead != NIL) node_next[ahead[5:0]] = after;
    else first_slot = after;
    if (after != NIL) node_prev[after[5:0]] = ahead;
    else last_slot = ahead;
    in_use[s] = 1'b0;
    free_slots[free_cnt] = s;
    free_cnt++;
    live_count--;
  endfunction

  function automatic outcome_t list_op_outcome(input logic [2:0] op, input logic [31:0] val,
                                               input logic [5:0] hnd);
    outcome_t   o;
    logic [5:0] s;
    logic [6:0] end_slot;
    o = '0;
    o.code = ST_OK;
    case (op)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (free_cnt == 0) begin
          o.code = ST_FULL;
        end else begin
          free_cnt--;
          s = free_slots[free_cnt];
          node_val[s] = val;
          in_use[s]   = 1'b1;
          if (first_slot == NIL) begin
            node_next[s] = NIL;
            node_prev[s] = NIL;
            first_slot   = {1'b0, s};
            last_slot    = {1'b0, s};
          end else if (op == CMD_PUSH_BACK) begin
            node_prev[s] = last_slot;
            node_next[s] = NIL;
            node_next[last_slot[5:0]] = {1'b0, s};
            last_slot = {1'b0, s};
          end else begin
            node_next[s] = first_slot;
            node_prev[s] = NIL;
            node_prev[first_slot[5:0]] = {1'b0, s};
            first_slot = {1'b0, s};
          end
          live_count++;
          o.slot = s;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        end_slot = (op == CMD_POP_BACK) ? last_slot : first_slot;
        if (end_slot == NIL) begin
          o.code = ST_EMPTY;
        end else begin
          o.value = node_val[end_slot[5:0]];
          o.slot  = end_slot[5:0];
          detach_slot(end_slot[5:0]);
        end
      end
      CMD_REMOVE: begin
        if (!in_use[hnd]) begin
          o.code = ST_BAD_SLOT;
        end else begin
          o.value = node_val[hnd];
          o.slot  = hnd;
          detach_slot(hnd);
        end
      end
      default: ;
    endcase
    o.total = 7'(live_count);
    return o;
  endfunction

  // Returns at the edge where the item was taken; valid is left high.
  task automatic send_item(input logic [2:0] op, input logic [31:0] val, input logic [5:0] hnd,
                           input logic typed, input outcome_t want);
    int       gap;
    outcome_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    cmd         <= op;
    payload     <= val;
    slot_handle <= hnd;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = list_op_outcome(op, val, hnd);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  // result side
  initial begin
    int       hold;
    outcome_t exp_o;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none awaited: payload %h handle %0d status %0d total %0d",
                   $realtime, out_payload, out_handle, status, element_total);
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (out_payload !== exp_o.value || out_handle !== exp_o.slot ||
            status !== exp_o.code || element_total !== exp_o.total) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp payload %h handle %0d status %0d total %0d, got %h %0d %0d %0d",
                     $realtime, exp_o.value, exp_o.slot, exp_o.code, exp_o.total,
                     out_payload, out_handle, status, element_total);
        end
      end
    end
  end

  initial begin
    int          sent;
    int          phase_len;
    int          push_pct;
    int          roll;
    logic [2:0]  op;
    logic [31:0] val;
    logic [5:0]  hnd;

    mismatches = 0;
    tx_burst   = 1'b0;
    rx_burst   = 1'b0;
    clear_list();
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    cmd          <= CMD_PUSH_BACK;
    payload      <= '0;
    slot_handle  <= '0;
    result_stall <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].slot,
                DIRECTED[i].typed, DIRECTED[i].want);

    // phases lean toward filling or draining so the pool hits full and empty
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(50, 200);
      case ($urandom_range(0, 2))
        0:       push_pct = 90;
        1:       push_pct = 50;
        default: push_pct = 12;
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len; k++) begin
        case ($urandom_range(0, 7))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase
        hnd  = 6'($urandom_range(0, SLOTS - 1));
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else begin
          case ($urandom_range(0, 9))
            0: op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            1: op = CMD_REMOVE;
            2, 3, 4, 5: begin
              op = CMD_REMOVE;
              // walk to a live slot
              if (live_count > 0)
                while (!in_use[hnd]) hnd = hnd + 6'd1;
            end
            default: op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
          endcase
        end
        send_item(op, val, hnd, 1'b0, '0);
        sent++;
      end
    end
    item_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: doubly_linked_list_engine.f
rtl/dll_pkg.sv
rtl/dll_ram.sv
rtl/doubly_linked_list_engine.sv
test/tb_doubly_linked_list_engine.sv
